/* rtl/psc_pkg.sv */
// Shared types and constants for the pressure sensor compensation block.
package psc_pkg;

  localparam int unsigned CAL_W  = 16;
  localparam int unsigned RAW_W  = 24;
  localparam int unsigned OUT_W  = 26;
  localparam int unsigned N_STG  = 12;

  // Calibration register indexes on the config channel
  typedef enum logic [2:0] {
    CFG_C1 = 3'd0,
    CFG_C2 = 3'd1,
    CFG_C3 = 3'd2,
    CFG_C4 = 3'd3,
    CFG_C5 = 3'd4,
    CFG_C6 = 3'd5
  } cfg_idx_t;

  typedef struct packed {
    logic [CAL_W-1:0] c1;
    logic [CAL_W-1:0] c2;
    logic [CAL_W-1:0] c3;
    logic [CAL_W-1:0] c4;
    logic [CAL_W-1:0] c5;
    logic [CAL_W-1:0] c6;
  } cal_t;

  // Temperature is carried as t = TEMP - 2000; TEMP < -1500 means t < -3500
  localparam logic signed [18:0] COLD_T    = -19'sd3500;
  localparam logic signed [19:0] COLD_BIAS = 20'sd3500;

  // n / 100 == (n * DIV100_MUL) >> 37 for any n below 2^32
  localparam logic [30:0] DIV100_MUL = 31'd1374389535;

endpackage

/* rtl/psc_cfg.sv */
// Calibration word register file written over the config channel.
module psc_cfg (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       cfg_valid,
  output logic                       cfg_ready,
  input  logic [2:0]                 cfg_index,
  input  logic [psc_pkg::CAL_W-1:0]  cfg_data,
  output psc_pkg::cal_t              cal
);

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cal <= '0;
    end else if (cfg_valid) begin
      case (psc_pkg::cfg_idx_t'(cfg_index))
        psc_pkg::CFG_C1: begin
          cal.c1 <= cfg_data;
        end
        psc_pkg::CFG_C2: begin
          cal.c2 <= cfg_data;
        end
        psc_pkg::CFG_C3: begin
          cal.c3 <= cfg_data;
        end
        psc_pkg::CFG_C4: begin
          cal.c4 <= cfg_data;
        end
        psc_pkg::CFG_C5: begin
          cal.c5 <= cfg_data;
        end
        psc_pkg::CFG_C6: begin
          cal.c6 <= cfg_data;
        end
        default: begin
          // unused index, write dropped
        end
      endcase
    end
  end

endmodule

/* rtl/pressure_sensor_compensation.sv */
// Top level: second-order pressure compensation pipeline, one sample pair per cycle unless the output stalls.
//
// Usage
//   Input channel s_*: one beat carries a raw pressure conversion (D1) and a
//   raw temperature conversion (D2). Output channel m_*: one beat per input
//   beat, in order, holding the compensated pressure / 100 as a signed
//   26-bit value (truncated toward zero, like C).
//   Config channel cfg_*: writes calibration words C1..C6 at index 0..5;
//   other indexes are dropped. cfg_ready is always high. Write only while
//   the pipeline is empty; words are read live by stages S1 to S3.
//   Pipeline: an accepted input beat moves through register stages S1..S12
//   in order, and m_tvalid rises once it reaches S12. Throughput: one beat
//   per cycle while m_tready stays high; the pipe is 12 register stages, with
//   the widest multiply (sensitivity x D1) split into two 40x13 partial products.
//   Stalls: each stage's ready is "empty or next stage ready", so bubbles
//   collapse and s_tready stays high while any stage has room; nothing is
//   dropped or repeated under backpressure.
//   Reset: rst (synchronous) empties the pipe and clears all calibration
//   words to zero.
module pressure_sensor_compensation (
  input  logic        clk,
  input  logic        rst,
  // slave side
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [47:0] s_tdata,   // [23:0] raw_pressure, [47:24] raw_temperature
  // master side
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [31:0] m_tdata,   // [25:0] compensated_pressure, [31:26] zero
  // config write channel
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [2:0]  cfg_index,
  input  logic [15:0] cfg_data
);

  localparam int unsigned N = psc_pkg::N_STG;

  psc_pkg::cal_t cal;

  psc_cfg u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cal       (cal)
  );

  // ---------------------------------------------------------------------
  // Stage handshake: vld[k] marks stage k+1 full, rdy[k] lets it load.
  // ---------------------------------------------------------------------
  logic [N-1:0] vld;
  logic [N:0]   rdy;

  always_comb begin
    rdy[N] = m_tready;
    for (int k = N - 1; k >= 0; k--) begin
      rdy[k] = !vld[k] || rdy[k+1];
    end
  end

  assign s_tready = rdy[0];
  assign m_tvalid = vld[N-1];

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else begin
      if (rdy[0]) begin
        vld[0] <= s_tvalid;
      end
      for (int k = 1; k < N; k++) begin
        if (rdy[k]) begin
          vld[k] <= vld[k-1];
        end
      end
    end
  end

  // ---------------------------------------------------------------------
  // Datapath
  // ---------------------------------------------------------------------
  logic [23:0] d1_in, d2_in;
  assign d1_in = s_tdata[23:0];
  assign d2_in = s_tdata[47:24];

  // S1: dT = D2 - C5*256
  logic signed [24:0] s1_dt, s1_dt_next;
  logic        [23:0] s1_d1;
  assign s1_dt_next = $signed({1'b0, d2_in}) - $signed({1'b0, cal.c5, 8'b0});

  // S2: the three products with dT
  logic signed [41:0] s2_mt, s2_m4, s2_m3;
  logic signed [41:0] s2_mt_next, s2_m4_next, s2_m3_next;
  logic        [23:0] s2_d1;
  assign s2_mt_next = s1_dt * $signed({1'b0, cal.c6});
  assign s2_m4_next = s1_dt * $signed({1'b0, cal.c4});
  assign s2_m3_next = s1_dt * $signed({1'b0, cal.c3});

  // S3: t = TEMP - 2000, squares, first-order offset and sensitivity
  logic signed [18:0] t3;
  logic signed [19:0] tc3;
  logic signed [37:0] sq_full;
  logic signed [39:0] sq2_full;
  logic signed [39:0] s3_off_base, s3_sens_base, off_base_next, sens_base_next;
  logic        [34:0] s3_sq;
  logic        [35:0] s3_sq2;
  logic               s3_neg, s3_cold;
  logic        [23:0] s3_d1;

  assign t3       = s2_mt[41:23];
  assign tc3      = $signed({t3[18], t3}) + psc_pkg::COLD_BIAS;
  assign sq_full  = t3 * t3;
  assign sq2_full = tc3 * tc3;
  assign off_base_next  = $signed({8'b0, cal.c2, 16'b0})
                        + $signed({{5{s2_m4[41]}}, s2_m4[41:7]});
  assign sens_base_next = $signed({9'b0, cal.c1, 15'b0})
                        + $signed({{6{s2_m3[41]}}, s2_m3[41:8]});

  // S4: band corrections applied
  logic        [38:0] off2;
  logic        [37:0] sens2;
  logic signed [39:0] s4_off, s4_sens, off_next, sens_next;
  logic        [23:0] s4_d1;

  always_comb begin
    if (s3_neg) begin
      off2  = ((39'(s3_sq) * 39'd3) >> 1)
            + (s3_cold ? (39'(s3_sq2) * 39'd7) : 39'd0);
      sens2 = ((38'(s3_sq) * 38'd5) >> 3)
            + (s3_cold ? {s3_sq2, 2'b00} : 38'd0);
    end else begin
      off2  = 39'(s3_sq) >> 4;
      sens2 = 38'd0;
    end
  end

  assign off_next  = s3_off_base  - $signed({1'b0, off2});
  assign sens_next = s3_sens_base - $signed({2'b0, sens2});

  // S5: SENS * D1 as two 12-bit halves of D1
  logic signed [52:0] s5_pl, s5_ph, pl_next, ph_next;
  logic signed [39:0] s5_off;
  assign pl_next = s4_sens * $signed({1'b0, s4_d1[11:0]});
  assign ph_next = s4_sens * $signed({1'b0, s4_d1[23:12]});

  // S6: recombine the full product
  logic signed [63:0] s6_prod, prod_next;
  logic signed [39:0] s6_off;
  assign prod_next = $signed({s5_ph[51:0], 12'b0}) + $signed({{11{s5_pl[52]}}, s5_pl});

  // S7: / 2^21, toward zero
  logic signed [63:0] pb1;
  logic signed [42:0] s7_q1;
  logic signed [39:0] s7_off;
  assign pb1 = s6_prod + $signed({43'd0, {21{s6_prod[63]}}});

  // S8: subtract offset
  logic signed [43:0] s8_diff, diff_next;
  assign diff_next = $signed({s7_q1[42], s7_q1}) - $signed({{4{s7_off[39]}}, s7_off});

  // S9: / 2^15, toward zero. |P| stays below 2^28 for any input, so the
  // 32-bit clamp can never engage and is not built.
  logic signed [43:0] pb2;
  logic signed [28:0] s9_p;
  assign pb2 = s8_diff + $signed({29'd0, {15{s8_diff[43]}}});

  // S10: sign and magnitude
  logic [27:0] s10_mag, mag_next;
  logic        s10_sign;
  logic [28:0] p_neg;
  assign p_neg    = -s9_p;
  assign mag_next = s9_p[28] ? p_neg[27:0] : s9_p[27:0];

  // S11: reciprocal multiply for / 100
  logic [58:0] s11_pm, pm_next;
  logic        s11_sign;
  assign pm_next = 59'(s10_mag) * 59'(psc_pkg::DIV100_MUL);

  // S12: output register
  logic [21:0]                     qm;
  logic [psc_pkg::OUT_W-1:0]       out_q, out_next;
  assign qm       = s11_pm[58:37];
  assign out_next = s11_sign ? (26'd0 - {4'b0, qm}) : {4'b0, qm};

  always_ff @(posedge clk) begin
    if (rdy[0]) begin
      s1_dt <= s1_dt_next;
      s1_d1 <= d1_in;
    end
    if (rdy[1]) begin
      s2_mt <= s2_mt_next;
      s2_m4 <= s2_m4_next;
      s2_m3 <= s2_m3_next;
      s2_d1 <= s1_d1;
    end
    if (rdy[2]) begin
      s3_sq        <= sq_full[34:0];
      s3_sq2       <= sq2_full[35:0];
      s3_neg       <= t3[18];
      s3_cold      <= (t3 < psc_pkg::COLD_T);
      s3_off_base  <= off_base_next;
      s3_sens_base <= sens_base_next;
      s3_d1        <= s2_d1;
    end
    if (rdy[3]) begin
      s4_off  <= off_next;
      s4_sens <= sens_next;
      s4_d1   <= s3_d1;
    end
    if (rdy[4]) begin
      s5_pl  <= pl_next;
      s5_ph  <= ph_next;
      s5_off <= s4_off;
    end
    if (rdy[5]) begin
      s6_prod <= prod_next;
      s6_off  <= s5_off;
    end
    if (rdy[6]) begin
      s7_q1  <= pb1[63:21];
      s7_off <= s6_off;
    end
    if (rdy[7]) begin
      s8_diff <= diff_next;
    end
    if (rdy[8]) begin
      s9_p <= pb2[43:15];
    end
    if (rdy[9]) begin
      s10_mag  <= mag_next;
      s10_sign <= s9_p[28];
    end
    if (rdy[10]) begin
      s11_pm   <= pm_next;
      s11_sign <= s10_sign;
    end
    if (rdy[11]) begin
      out_q <= out_next;
    end
  end

  assign m_tdata = {6'b0, out_q};

  // ---------------------------------------------------------------------
  // Assertions
  // ---------------------------------------------------------------------
  a_occ_up: assert property (@(posedge clk) disable iff (rst)
    (s_tvalid && s_tready && !(m_tvalid && m_tready))
      |=> ($countones(vld) == $past($countones(vld)) + 1))
    else $error("pipe occupancy did not grow on an input-only beat");

  a_out_range: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> ($signed(out_q) <= 26'sd21474836 && $signed(out_q) >= -26'sd21474836))
    else $error("result outside the saturated range");

  a_band: assert property (@(posedge clk) disable iff (rst)
    (vld[2] && s3_cold) |-> s3_neg)
    else $error("cold band flagged above 20.0 C");

  a_hold: assert property (@(posedge clk) disable iff (rst)
    (vld[5] && !rdy[5]) |=> (vld[5] && $stable(s6_prod)))
    else $error("stalled product stage lost or changed its beat");

endmodule
